### rtl/audio_silence_trimmer_assert.svh
// assertion macros used by the silence trimmer top level
`ifndef AUDIO_SILENCE_TRIMMER_ASSERT_SVH
`define AUDIO_SILENCE_TRIMMER_ASSERT_SVH

// condition holds on every rising clock edge out of reset
`define AST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger in this cycle implies consequence in the next
`define AST_ASSERT_NEXT(label, trig, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (consq)) \
        else $error(msg);

`endif

### rtl/ast_pkg.sv
// types and constants for the audio silence trimmer
package ast_pkg;

    localparam int MAX_PACKET_SAMPLES = 4096;
    localparam int CNT_W              = $clog2(MAX_PACKET_SAMPLES + 1);

    localparam logic [15:0] THRESHOLD_RESET = 16'd64;

    // input commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_EMPTY  = 2'd1;
    localparam logic [1:0] CMD_SEEK   = 2'd2;

    // descriptor actions
    localparam logic [1:0] ACT_FORWARD = 2'd0;
    localparam logic [1:0] ACT_EMPTIED = 2'd1;
    localparam logic [1:0] ACT_DROP    = 2'd2;

    // descriptor queue, depth a power of two
    localparam int DESC_FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W      = $clog2(DESC_FIFO_DEPTH);
    localparam int FIFO_CNT_W      = $clog2(DESC_FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               packet_end;
        logic               end_of_stream_flag;
        logic               start_of_stream_flag;
        logic               other_flag;
    } item_t;

    typedef struct packed {
        logic [15:0]      packet_id;
        logic [1:0]       action;
        logic [CNT_W-1:0] start_sample;
        logic [CNT_W-1:0] kept_length;
        logic             last_result;
    } desc_t;

    typedef struct packed {
        logic [1:0] count;
        desc_t      first;
        desc_t      second;
    } fifo_push_t;

endpackage

### rtl/ast_desc_fifo.sv
// descriptor queue: takes up to two descriptors a cycle, hands out one while desc_stall is low
module ast_desc_fifo
    import ast_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ast_pkg::fifo_push_t push,
    output logic                room,
    output logic                desc_valid,
    input  logic                desc_stall,
    output ast_pkg::desc_t      desc
);
    import ast_pkg::*;

    desc_t                 entries_reg [DESC_FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic                  pop;

    assign desc_valid   = (count_reg != '0);
    assign desc         = entries_reg[rd_ptr_reg];
    assign pop          = desc_valid && !desc_stall;
    assign room         = (count_reg <= FIFO_CNT_W'(DESC_FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entries_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

### rtl/audio_silence_trimmer.sv
// Audio silence trimmer top level
//
// Input channel item/item_valid/item_stall carries one command per transfer:
// a stereo sample, an empty packet end, or a seek. The packet analysis and
// descriptor decision are done in the cycle an item is taken, so items may
// follow each other in every cycle. Each packet end yields zero, one or two
// packet descriptors on desc/desc_valid/desc_stall; last_result marks the
// final descriptor of one input.
// A descriptor is registered into the queue when its input is taken.
// One item is taken per cycle while item_stall is low; descriptors leave at
// one per cycle while desc_stall is low, through a four-entry queue, and
// item_stall rises while the queue has fewer than two free entries. The
// silence threshold is to be written through threshold_we/threshold_wdata
// only while the block is idle, a rule on the user; reset sets it to 64.
// Reset empties the queue, drops any held packet, clears the packet counter
// and returns to start-of-stream mode. A stalled receiver fills the queue and
// then stalls the input side; nothing is lost.
module audio_silence_trimmer
    import ast_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  ast_pkg::item_t item,
    output logic           desc_valid,
    input  logic           desc_stall,
    output ast_pkg::desc_t desc,
    input  logic           threshold_we,
    input  logic [15:0]    threshold_wdata
);
    import ast_pkg::*;

    `include "audio_silence_trimmer_assert.svh"

    logic [15:0]      threshold_reg;
    logic             stream_mode_reg;
    logic             stream_mode_next;
    logic [CNT_W-1:0] seen_reg;
    logic [CNT_W-1:0] seen_next;
    logic [CNT_W-1:0] lead_reg;
    logic [CNT_W-1:0] lead_next;
    logic [CNT_W-1:0] loud_end_reg;
    logic [CNT_W-1:0] loud_end_next;
    logic [15:0]      counter_reg;
    logic [15:0]      counter_next;
    logic             held_valid_reg;
    logic             held_valid_next;
    logic [15:0]      held_id_reg;
    logic [CNT_W-1:0] held_length_reg;
    logic [CNT_W-1:0] held_trailing_reg;
    logic             hold_new;

    logic             accept;
    logic             fifo_room;
    fifo_push_t       push;

    logic [16:0]      left_ext;
    logic [16:0]      right_ext;
    logic [16:0]      left_mag;
    logic [16:0]      right_mag;
    logic             silent;
    logic             counting;
    logic             finishing;
    logic             flagged;
    logic [CNT_W-1:0] n_upd;
    logic [CNT_W-1:0] lead_upd;
    logic [CNT_W-1:0] loud_upd;
    logic [CNT_W-1:0] trail;
    logic             all_silent;
    logic             rel_req;
    logic             rel_trim;
    logic             rel_emit;
    logic             new_emit;
    desc_t            rel_desc;
    desc_t            new_desc;

    assign accept     = item_valid && !item_stall;
    assign item_stall = !fifo_room;

    // magnitude compare: -t < x < t is |x| < t
    assign left_ext  = {item.left_sample[15], item.left_sample};
    assign right_ext = {item.right_sample[15], item.right_sample};
    assign left_mag  = left_ext[16] ? 17'd0 - left_ext : left_ext;
    assign right_mag = right_ext[16] ? 17'd0 - right_ext : right_ext;
    assign silent    = (left_mag < {1'b0, threshold_reg})
                       && (right_mag < {1'b0, threshold_reg});

    assign counting  = (item.cmd == CMD_SAMPLE)
                       && (seen_reg < CNT_W'(MAX_PACKET_SAMPLES));
    assign finishing = accept && ((item.cmd == CMD_EMPTY)
                       || ((item.cmd == CMD_SAMPLE) && item.packet_end));
    assign flagged   = item.end_of_stream_flag || item.start_of_stream_flag
                       || item.other_flag;

    always_comb
    begin
        n_upd    = seen_reg;
        lead_upd = lead_reg;
        loud_upd = loud_end_reg;
        if (counting)
        begin
            n_upd = seen_reg + CNT_W'(1);
            if (!silent)
            begin
                loud_upd = seen_reg + CNT_W'(1);
            end
            else if (lead_reg == seen_reg)
            begin
                lead_upd = lead_reg + CNT_W'(1);
            end
        end
    end

    assign trail      = (loud_upd != '0) ? n_upd - loud_upd : '0;
    assign all_silent = (lead_upd == n_upd);

    // packet decision
    always_comb
    begin
        rel_req          = 1'b0;
        rel_trim         = 1'b0;
        new_emit         = 1'b0;
        hold_new         = 1'b0;
        stream_mode_next = stream_mode_reg;
        new_desc         = '{packet_id: counter_reg, action: ACT_FORWARD,
                             start_sample: '0, kept_length: '0, last_result: 1'b0};
        if (all_silent)
        begin
            new_emit = 1'b1;
            if (flagged)
            begin
                rel_req         = 1'b1;
                rel_trim        = stream_mode_reg;
                new_desc.action = ACT_EMPTIED;
            end
            else
            begin
                new_desc.action = ACT_DROP;
            end
        end
        else if (!stream_mode_reg)
        begin
            rel_req               = 1'b1;
            new_emit              = 1'b1;
            new_desc.start_sample = lead_upd;
            new_desc.kept_length  = n_upd - lead_upd;
            if (!item.end_of_stream_flag)
            begin
                stream_mode_next = 1'b1;
            end
        end
        else
        begin
            rel_req = 1'b1;
            if (trail != '0)
            begin
                hold_new = 1'b1;
            end
            else
            begin
                new_emit             = 1'b1;
                new_desc.kept_length = n_upd;
            end
        end
        if (stream_mode_reg && (item.end_of_stream_flag || item.start_of_stream_flag))
        begin
            stream_mode_next = 1'b0;
        end
    end

    assign rel_emit = rel_req && held_valid_reg;

    always_comb
    begin
        rel_desc = '{packet_id: held_id_reg, action: ACT_FORWARD, start_sample: '0,
                     kept_length: rel_trim ? held_length_reg - held_trailing_reg
                                           : held_length_reg,
                     last_result: !new_emit};
        push.count  = 2'd0;
        push.first  = rel_emit ? rel_desc : new_desc;
        push.second = new_desc;
        push.first.last_result  = !(rel_emit && new_emit);
        push.second.last_result = 1'b1;
        if (finishing)
        begin
            push.count = {1'b0, rel_emit} + {1'b0, new_emit};
        end
    end

    // state update
    always_comb
    begin
        seen_next       = seen_reg;
        lead_next       = lead_reg;
        loud_end_next   = loud_end_reg;
        counter_next    = counter_reg;
        held_valid_next = held_valid_reg;
        if (accept)
        begin
            unique case (item.cmd)
                CMD_SEEK:
                begin
                    held_valid_next = 1'b0;
                end
                CMD_SAMPLE:
                begin
                    seen_next     = n_upd;
                    lead_next     = lead_upd;
                    loud_end_next = loud_upd;
                end
                default:
                begin
                end
            endcase
        end
        if (finishing)
        begin
            seen_next       = '0;
            lead_next       = '0;
            loud_end_next   = '0;
            counter_next    = counter_reg + 16'd1;
            held_valid_next = hold_new || (held_valid_reg && !rel_req);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            stream_mode_reg <= 1'b0;
            seen_reg        <= '0;
            lead_reg        <= '0;
            loud_end_reg    <= '0;
            counter_reg     <= '0;
            held_valid_reg  <= 1'b0;
        end
        else
        begin
            if (threshold_we)
            begin
                threshold_reg <= threshold_wdata;
            end
            if (finishing)
            begin
                stream_mode_reg <= stream_mode_next;
            end
            seen_reg       <= seen_next;
            lead_reg       <= lead_next;
            loud_end_reg   <= loud_end_next;
            counter_reg    <= counter_next;
            held_valid_reg <= held_valid_next;
        end
    end

    // held packet details, only read while held_valid_reg is set
    always_ff @(posedge clk)
    begin
        if (finishing && hold_new)
        begin
            held_id_reg       <= counter_reg;
            held_length_reg   <= n_upd;
            held_trailing_reg <= trail;
        end
    end

    ast_desc_fifo u_desc_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (fifo_room),
        .desc_valid (desc_valid),
        .desc_stall (desc_stall),
        .desc       (desc)
    );

    `AST_ASSERT_NEXT(a_seek_drops_held, accept && (item.cmd == CMD_SEEK), !held_valid_reg, "held packet survived a seek")
    `AST_ASSERT_ALWAYS(a_seen_bounded, seen_reg <= CNT_W'(MAX_PACKET_SAMPLES), "sample count beyond packet limit")
    `AST_ASSERT_ALWAYS(a_runs_within_packet, (lead_reg <= seen_reg) && (loud_end_reg <= seen_reg), "silence run or loud end beyond sample count")
    `AST_ASSERT_NEXT(a_finish_clears_counts, finishing, (seen_reg == '0) && (lead_reg == '0) && (loud_end_reg == '0), "packet counts not cleared at packet end")

endmodule
